### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent on one edge implies the consequent on the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/eipe_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eipe_pkg
// Constants and divider request/response types for the power estimator.
// ---------------------------------------------------------------------------
package eipe_pkg;

	localparam int NUM_SLOTS      = 11;
	localparam int AVERAGED_SLOTS = 10;
	localparam int AVG_SLOTS      = (AVERAGED_SLOTS < NUM_SLOTS) ? AVERAGED_SLOTS : NUM_SLOTS;

	localparam int SLOT_W  = 4;
	localparam int DATA_W  = 32;
	localparam int AW_W    = 23;
	localparam int ADDR_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W   = $clog2(AVG_SLOTS + 1);
	localparam int SUM_W   = DATA_W + CNT_W;
	localparam int HOUR_W  = 22;
	localparam int DIV_W   = DATA_W + HOUR_W;
	localparam int DIV_LEN_W = $clog2(DIV_W + 1);

	localparam logic [HOUR_W-1:0]    MS_PER_HOUR = 22'd3600000;
	localparam logic [DATA_W-1:0]    MAX_GAP_RST = 32'd300000;
	localparam logic [DATA_W:0]      HALF_WATT   = 33'd500;
	localparam logic [DATA_W-1:0]    MW_PER_W    = 32'd1000;

	// Dividend lengths in bits; the dividend is left aligned in DIV_W bits.
	localparam logic [DIV_LEN_W-1:0] LEN_POWER = DIV_LEN_W'(DIV_W);
	localparam logic [DIV_LEN_W-1:0] LEN_WATT  = DIV_LEN_W'(DATA_W + 1);
	localparam logic [DIV_LEN_W-1:0] LEN_AVG   = DIV_LEN_W'(SUM_W);

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DATA_W-1:0]    divisor;
		logic [DIV_LEN_W-1:0] len;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

### hw/rtl/eipe_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eipe_if
// Valid/ready channels: reading request, result, and limit register write.
// ---------------------------------------------------------------------------
interface eipe_item_if;
	import eipe_pkg::*;
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] slot;
	logic [DATA_W-1:0] energy_mwh;
	logic [DATA_W-1:0] time_ms;

	modport source (output valid, slot, energy_mwh, time_ms, input ready);
	modport sink   (input valid, slot, energy_mwh, time_ms, output ready);
endinterface

interface eipe_result_if;
	import eipe_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] power_mw;
	logic [AW_W-1:0]   active_power_w;
	logic              active_valid;
	logic [DATA_W-1:0] average_power_mw;

	modport source (output valid, power_mw, active_power_w, active_valid,
		average_power_mw, input ready);
	modport sink   (input valid, power_mw, active_power_w, active_valid,
		average_power_mw, output ready);
endinterface

interface eipe_cfg_if;
	import eipe_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] max_gap_ms;

	modport source (output valid, max_gap_ms, input ready);
	modport sink   (input valid, max_gap_ms, output ready);
endinterface

### hw/rtl/eipe_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eipe_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module eipe_div (
	input  logic               clk,
	input  logic               arst_n,
	input  eipe_pkg::div_req_t req,
	output eipe_pkg::div_rsp_t rsp
);
	import eipe_pkg::*;

	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    dsr_q;
	logic [DIV_W-1:0]     num_q;
	logic [DIV_LEN_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DATA_W:0]      rem_sh;
	logic [DATA_W:0]      diff;
	logic                 ge;

	assign rem_sh = {rem_q, num_q[DIV_W-1]};
	assign diff   = rem_sh - {1'b0, dsr_q};
	assign ge     = (rem_sh >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_LEN_W'(1);
				if (cnt_q == DIV_LEN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out at the top, quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
			num_q <= {num_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

### hw/rtl/eipe_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eipe_seq
// Per-reading sequencer: slot tables, running sum, divider requests, result.
// ---------------------------------------------------------------------------
module eipe_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	eipe_item_if.sink                       item,
	eipe_result_if.source                   result,
	input  logic [eipe_pkg::DATA_W-1:0]     max_gap,
	output eipe_pkg::div_req_t              div_req,
	input  eipe_pkg::div_rsp_t              div_rsp
);
	import eipe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_EVAL, S_MUL, S_PWAIT, S_STORE, S_AREAD,
		S_ADIV, S_AWAIT, S_AVG, S_VWAIT, S_DONE
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [DATA_W-1:0]   energy_q;
	logic [DATA_W-1:0]   time_q;
	logic                in_range_q;
	logic [NUM_SLOTS-1:0] primed_q;
	logic [DATA_W-1:0]   delta_q;
	logic [DATA_W-1:0]   gap_q;
	logic                rise_q;
	logic                was_primed_q;
	logic                do_div_q;
	logic [DATA_W-1:0]   power_q;
	logic [SLOT_W-1:0]   active_slot_q;
	logic                active_set_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    count_q;
	logic [AW_W-1:0]     aw_q;
	logic [DATA_W-1:0]   avg_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_power_q;
	logic [AW_W-1:0]     out_aw_q;
	logic                out_act_q;
	logic [DATA_W-1:0]   out_avg_q;

	// slot tables, read data registered
	logic [DATA_W-1:0]   energy_mem [NUM_SLOTS];
	logic [DATA_W-1:0]   time_mem   [NUM_SLOTS];
	logic [DATA_W-1:0]   power_mem  [NUM_SLOTS];
	logic [DATA_W-1:0]   rd_energy_q;
	logic [DATA_W-1:0]   rd_time_q;
	logic [DATA_W-1:0]   rd_power_q;

	logic                accept;
	logic                item_in_range;
	logic                in_avg;
	logic                do_div;
	logic                mem_we;
	logic                mem_re;
	logic [ADDR_W-1:0]   rd_addr;
	logic [DIV_W-1:0]    product;
	logic [DATA_W:0]     rounded;
	logic [DATA_W-1:0]   sat_power;

	assign item.ready    = (state_q == S_IDLE);
	assign accept        = item.valid && item.ready;
	assign item_in_range = ({1'b0, item.slot} < (SLOT_W + 1)'(NUM_SLOTS));
	assign in_avg        = ({1'b0, slot_q} < (SLOT_W + 1)'(AVG_SLOTS));
	assign do_div        = was_primed_q && rise_q && (gap_q != '0) && (gap_q <= max_gap);
	assign product       = delta_q * MS_PER_HOUR;
	assign rounded       = {1'b0, rd_power_q} + HALF_WATT;
	assign sat_power     = (|div_rsp.quotient[DIV_W-1:DATA_W]) ? '1
		: div_rsp.quotient[DATA_W-1:0];

	assign mem_we  = (state_q == S_STORE) && in_range_q;
	assign mem_re  = (accept && item_in_range) || (state_q == S_AREAD);
	assign rd_addr = (state_q == S_AREAD) ? active_slot_q[ADDR_W-1:0] : item.slot[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			energy_mem[slot_q[ADDR_W-1:0]] <= energy_q;
			time_mem[slot_q[ADDR_W-1:0]]   <= time_q;
			power_mem[slot_q[ADDR_W-1:0]]  <= power_q;
		end
		if (mem_re) begin
			rd_energy_q <= energy_mem[rd_addr];
			rd_time_q   <= time_mem[rd_addr];
			rd_power_q  <= power_mem[rd_addr];
		end
	end

	always_comb begin
		div_req = '0;
		case (state_q)
			S_MUL: begin
				div_req.start    = do_div;
				div_req.dividend = product;
				div_req.divisor  = gap_q;
				div_req.len      = LEN_POWER;
			end
			S_ADIV: begin
				div_req.start    = active_set_q;
				div_req.dividend = {rounded, {(DIV_W - DATA_W - 1){1'b0}}};
				div_req.divisor  = MW_PER_W;
				div_req.len      = LEN_WATT;
			end
			S_AVG: begin
				div_req.start    = (count_q != '0);
				div_req.dividend = {sum_q, {(DIV_W - SUM_W){1'b0}}};
				div_req.divisor  = DATA_W'(count_q);
				div_req.len      = LEN_AVG;
			end
			default: div_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			slot_q        <= '0;
			energy_q      <= '0;
			time_q        <= '0;
			in_range_q    <= 1'b0;
			primed_q      <= '0;
			delta_q       <= '0;
			gap_q         <= '0;
			rise_q        <= 1'b0;
			was_primed_q  <= 1'b0;
			do_div_q      <= 1'b0;
			power_q       <= '0;
			active_slot_q <= '0;
			active_set_q  <= 1'b0;
			sum_q         <= '0;
			count_q       <= '0;
			aw_q          <= '0;
			avg_q         <= '0;
			out_valid_q   <= 1'b0;
			out_power_q   <= '0;
			out_aw_q      <= '0;
			out_act_q     <= 1'b0;
			out_avg_q     <= '0;
		end else begin
			// S_DONE reloads the register itself when it frees
			if (out_valid_q && result.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						slot_q     <= item.slot;
						energy_q   <= item.energy_mwh;
						time_q     <= item.time_ms;
						in_range_q <= item_in_range;
						state_q    <= S_EVAL;
					end
				end
				S_EVAL: begin
					delta_q      <= energy_q - rd_energy_q;
					gap_q        <= time_q - rd_time_q;
					rise_q       <= (energy_q > rd_energy_q);
					was_primed_q <= in_range_q && primed_q[slot_q[ADDR_W-1:0]];
					state_q      <= S_MUL;
				end
				S_MUL: begin
					do_div_q <= do_div;
					power_q  <= '0;
					state_q  <= do_div ? S_PWAIT : S_STORE;
				end
				S_PWAIT: begin
					if (div_rsp.done) begin
						power_q <= sat_power;
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (in_range_q) begin
						primed_q[slot_q[ADDR_W-1:0]] <= 1'b1;
						if (in_avg) begin
							sum_q <= sum_q - (was_primed_q ? SUM_W'(rd_power_q) : '0)
								+ SUM_W'(power_q);
							if (!was_primed_q) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						if (do_div_q) begin
							active_slot_q <= slot_q;
							active_set_q  <= 1'b1;
						end
					end
					state_q <= S_AREAD;
				end
				S_AREAD: begin
					state_q <= S_ADIV;
				end
				S_ADIV: begin
					aw_q    <= '0;
					state_q <= active_set_q ? S_AWAIT : S_AVG;
				end
				S_AWAIT: begin
					if (div_rsp.done) begin
						aw_q    <= div_rsp.quotient[AW_W-1:0];
						state_q <= S_AVG;
					end
				end
				S_AVG: begin
					avg_q   <= '0;
					state_q <= (count_q != '0) ? S_VWAIT : S_DONE;
				end
				S_VWAIT: begin
					if (div_rsp.done) begin
						avg_q   <= div_rsp.quotient[DATA_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_power_q <= power_q;
						out_aw_q    <= aw_q;
						out_act_q   <= active_set_q;
						out_avg_q   <= avg_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid            = out_valid_q;
	assign result.power_mw         = out_power_q;
	assign result.active_power_w   = out_aw_q;
	assign result.active_valid     = out_act_q;
	assign result.average_power_mw = out_avg_q;

endmodule

### hw/rtl/energy_index_power_estimator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// energy_index_power_estimator
// Power estimate per meter slot from cumulative energy readings, plus the
// active slot's power in watts and the mean over the averaged slots.
// ---------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   item     in   valid/ready   slot, energy_mwh, time_ms
//   result   out  valid/ready   power_mw, active_power_w, active_valid,
//                               average_power_mw
//   cfg      in   valid/ready   max_gap_ms (ready always high)
//
// One request is processed at a time; item.ready is high only while idle.
// The single bit-serial divider sets how long a request takes: it runs the
// power quotient, the watt rounding and the mean in turn, each only when
// that division is needed, and hands each quotient back when done.
// The result register lets a new request in while the last result waits;
// a finished request holds in its last step until that register frees.
// Reset (arst_n low) clears all slots, the running sum and the active slot,
// and sets max_gap_ms to 300000.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module energy_index_power_estimator (
	input  logic          clk,
	input  logic          arst_n,
	eipe_item_if.sink     item,
	eipe_result_if.source result,
	eipe_cfg_if.sink      cfg
);
	import eipe_pkg::*;

	logic [DATA_W-1:0] max_gap_q;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// limit register; writes must only come while idle (the user's duty, not enforced here)
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= MAX_GAP_RST;
		end else if (cfg.valid && cfg.ready) begin
			max_gap_q <= cfg.max_gap_ms;
		end
	end

	// sequencer: slot tables, sum/count, result register
	eipe_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.result  (result),
		.max_gap (max_gap_q),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	// shared serial divider
	eipe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	`ASSERT_ALWAYS(a_div_start_idle, div_req.start |-> !div_rsp.busy,
		"divider restarted while busy")
	`ASSERT_ALWAYS(a_div_done_after_busy, div_rsp.done |-> $past(div_rsp.busy),
		"divider done without run")
	`ASSERT_NEXT(a_one_request, item.valid && item.ready, !item.ready,
		"second request taken mid run")
	`ASSERT_ALWAYS(a_watts_need_active,
		(result.valid && !result.active_valid) |-> (result.active_power_w == '0),
		"watts without active slot")

endmodule
